@@ design/aoc_pkg.sv @@
// Package for the alpha-over compositor: widths, defaults, register codes and shared types.
`default_nettype none
package aoc_pkg;
	// Default build parameters
	localparam int CHANNELS_DEF    = 4;
	localparam int SAMPLE_BITS_DEF = 16;

	// Fixed field widths of the ports
	localparam int NCH_MAX    = 4;
	localparam int POS_W      = 12;
	localparam int SAMPLE_W   = 16;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 13;
	localparam int IN_DATA_W  = 2 * POS_W + 2 * NCH_MAX * SAMPLE_W;
	localparam int OUT_DATA_W = NCH_MAX * SAMPLE_W;

	// Configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_OPACITY_CHANNEL = 3'd0,
		REG_OFFSET_X        = 3'd1,
		REG_OFFSET_Y        = 3'd2,
		REG_OVERLAY_WIDTH   = 3'd3,
		REG_OVERLAY_HEIGHT  = 3'd4
	} cfg_reg_t;

	// Sideband that rides alongside the divider lanes
	typedef struct packed {
		logic                              cov;
		logic [1:0]                        opch;
		logic [NCH_MAX*SAMPLE_W-1:0]       base;
	} side_t;
endpackage
`default_nettype wire

@@ design/aoc_div_pipe.sv @@
// Pipelined restoring divider: one quotient bit per register stage.
`default_nettype none
module aoc_div_pipe #(
	parameter int DW = 32,
	parameter int QB = 17
) (
	input  wire logic             clk,
	input  wire logic             en,
	input  wire logic [DW+QB-1:0] num,
	input  wire logic [DW-1:0]    den,
	output logic      [QB-1:0]    quo
);
	// Per-stage partial remainder, divisor, pending low bits, quotient so far
	logic [DW-1:0] rem_s [QB];
	logic [DW-1:0] den_s [QB];
	logic [QB-1:0] low_s [QB];
	logic [QB-1:0] q_s   [QB];

	for (genvar k = 0; k < QB; k++) begin : g_stage
		logic [DW-1:0] prev_rem;
		logic [DW-1:0] prev_den;
		logic [QB-1:0] prev_low;
		logic [QB-1:0] prev_q;
		logic [DW:0]   trial;
		logic          ge;
		logic [DW:0]   diff;
		logic [QB-1:0] next_q;

		// Inputs of this stage
		always_comb begin
			if (k == 0) begin
				prev_rem = num[DW+QB-1:QB];
				prev_den = den;
				prev_low = num[QB-1:0];
				prev_q   = '0;
			end else begin
				prev_rem = rem_s[k-1];
				prev_den = den_s[k-1];
				prev_low = low_s[k-1];
				prev_q   = q_s[k-1];
			end
		end

		// Shift in one numerator bit, subtract when it fits
		always_comb begin
			trial  = {prev_rem, prev_low[QB-1-k]};
			ge     = trial >= {1'b0, prev_den};
			diff   = trial - {1'b0, prev_den};
			next_q = prev_q;
			next_q[QB-1-k] = ge;
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k] <= ge ? diff[DW-1:0] : trial[DW-1:0];
				den_s[k] <= prev_den;
				low_s[k] <= prev_low;
				q_s[k]   <= next_q;
			end
		end
	end

	assign quo = q_s[QB-1];
endmodule
`default_nettype wire

@@ design/alpha_over_compositor_core.sv @@
// Alpha-over compositor: window test, weights, products and a pipelined divider per channel.
//
// Usage: pixels enter on the s_ group (tvalid/tready/tdata); each transfer carries the
// base pixel position, its four channel samples and the overlay samples at the offset
// position. Results leave on the m_ group: four composited samples in m_tdata and the
// covered flag in m_tuser. Configuration is written through cfg_we/cfg_index/cfg_data
// while the block is idle.
// Throughput: one pixel per clock cycle, sustained while the receiver takes results.
// Pipeline: 4 stages for window test, weights, products and numerator build, then
// 17 divider stages (one quotient bit each), and the output register.
// Reset (arst_n low) empties the pipeline and loads the register defaults: opacity in
// channel 3, zero offsets, a 4096 by 4096 window.
// When the receiver stalls with a result waiting, the whole pipeline holds in place;
// s_tready drops only then, and nothing is lost or repeated.
`default_nettype none
module alpha_over_compositor_core #(
	parameter int CHANNELS    = aoc_pkg::CHANNELS_DEF,
	parameter int SAMPLE_BITS = aoc_pkg::SAMPLE_BITS_DEF
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	// pos_x, pos_y, base_ch0..3, over_ch0..3 (lowest bit first)
	input  wire logic [aoc_pkg::IN_DATA_W-1:0]    s_tdata,
	input  wire logic                             s_tvalid,
	output logic                                  s_tready,
	// out_ch0..3 (lowest bit first)
	output logic      [aoc_pkg::OUT_DATA_W-1:0]   m_tdata,
	// covered
	output logic                                  m_tuser,
	output logic                                  m_tvalid,
	input  wire logic                             m_tready,
	input  wire logic                             cfg_we,
	input  wire logic [aoc_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  wire logic [aoc_pkg::CFG_DATA_W-1:0]   cfg_data
);
	localparam int SW  = aoc_pkg::SAMPLE_W;
	localparam int NCH = aoc_pkg::NCH_MAX;
	localparam int PW  = aoc_pkg::POS_W;
	localparam int SB  = SAMPLE_BITS;
	localparam int WW  = SB + SW;
	localparam int QB  = SW + 1;
	localparam int NW  = WW + QB;
	localparam logic [SB-1:0] FULL = {SB{1'b1}};
	localparam logic [SW-1:0] LIM  = (SB < SW) ? SW'((1 << SB) - 1) : {SW{1'b1}};

	// Configuration registers
	logic [1:0]  opch_q;
	logic [12:0] off_x_q;
	logic [12:0] off_y_q;
	logic [12:0] width_q;
	logic [12:0] height_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			opch_q   <= 2'd3;
			off_x_q  <= '0;
			off_y_q  <= '0;
			width_q  <= 13'h1000;
			height_q <= 13'h1000;
		end else if (cfg_we) begin
			case (aoc_pkg::cfg_reg_t'(cfg_index))
				aoc_pkg::REG_OPACITY_CHANNEL: opch_q   <= cfg_data[1:0];
				aoc_pkg::REG_OFFSET_X:        off_x_q  <= cfg_data;
				aoc_pkg::REG_OFFSET_Y:        off_y_q  <= cfg_data;
				aoc_pkg::REG_OVERLAY_WIDTH:   width_q  <= cfg_data;
				aoc_pkg::REG_OVERLAY_HEIGHT:  height_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Global advance: everything moves unless a result waits on a stalled receiver
	logic en;
	assign en       = !m_tvalid || m_tready;
	assign s_tready = en;

	// Input unpacking, window test and clamping
	logic [PW-1:0]       pos_x;
	logic [PW-1:0]       pos_y;
	logic signed [13:0]  dx;
	logic signed [13:0]  dy;
	logic                win;
	logic [SW-1:0]       base_in [NCH];
	logic [SW-1:0]       base_cl [NCH];
	logic [SW-1:0]       over_cl [NCH];

	always_comb begin
		pos_x = s_tdata[PW-1:0];
		pos_y = s_tdata[2*PW-1:PW];
		for (int c = 0; c < NCH; c++) begin
			base_in[c] = s_tdata[2*PW + c*SW +: SW];
			base_cl[c] = (base_in[c] > LIM) ? LIM : base_in[c];
			over_cl[c] = (s_tdata[2*PW + (NCH+c)*SW +: SW] > LIM) ? LIM
			             : s_tdata[2*PW + (NCH+c)*SW +: SW];
		end
		dx  = $signed({2'b00, pos_x}) - $signed({off_x_q[12], off_x_q});
		dy  = $signed({2'b00, pos_y}) - $signed({off_y_q[12], off_y_q});
		win = !dx[13] && !dy[13] && (dx[12:0] < width_q) && (dy[12:0] < height_q)
		      && ({1'b0, opch_q} < 3'(CHANNELS));
	end

	// Stage 1: registered window result and clamped samples
	logic          v_s1;
	logic          win_s1;
	logic [1:0]    opch_s1;
	logic [SW-1:0] base_s1    [NCH];
	logic [SW-1:0] base_cl_s1 [NCH];
	logic [SW-1:0] over_cl_s1 [NCH];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			win_s1     <= win;
			opch_s1    <= opch_q;
			base_s1    <= base_in;
			base_cl_s1 <= base_cl;
			over_cl_s1 <= over_cl;
		end
	end

	// Stage 2: weights wb = b*S and wa = (S-b)*a
	logic          v_s2;
	logic          win_s2;
	logic [1:0]    opch_s2;
	logic [SW-1:0] base_s2    [NCH];
	logic [SW-1:0] base_cl_s2 [NCH];
	logic [SW-1:0] over_cl_s2 [NCH];
	logic [WW-1:0] wb_s2;
	logic [WW-1:0] wa_s2;
	logic [WW-1:0] b_w;
	logic [SB-1:0] omb;

	always_comb begin
		b_w = WW'(over_cl_s1[opch_s1]);
		omb = FULL - SB'(over_cl_s1[opch_s1]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			win_s2     <= win_s1;
			opch_s2    <= opch_s1;
			base_s2    <= base_s1;
			base_cl_s2 <= base_cl_s1;
			over_cl_s2 <= over_cl_s1;
			wb_s2      <= (b_w << SB) - b_w;
			wa_s2      <= WW'(omb) * WW'(base_cl_s1[opch_s1]);
		end
	end

	// Stage 3: new opacity sum and per-channel weighted products
	logic          v_s3;
	logic          win_s3;
	logic [1:0]    opch_s3;
	logic [SW-1:0] base_s3 [NCH];
	logic [WW-1:0] nc_s3;
	logic [NW-1:0] pa_s3 [CHANNELS];
	logic [NW-1:0] pb_s3 [CHANNELS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			win_s3  <= win_s2;
			opch_s3 <= opch_s2;
			base_s3 <= base_s2;
			nc_s3   <= wb_s2 + wa_s2;
			for (int c = 0; c < CHANNELS; c++) begin
				pa_s3[c] <= NW'(wb_s2) * NW'(over_cl_s2[c]);
				pb_s3[c] <= NW'(wa_s2) * NW'(base_cl_s2[c]);
			end
		end
	end

	// Stage 4: numerator and divisor per lane; the opacity lane divides by 2S
	logic           v_s4;
	aoc_pkg::side_t side_s4;
	logic [NW-1:0]  num_s4 [CHANNELS];
	logic [WW-1:0]  den_s4 [CHANNELS];
	logic [NCH*SW-1:0] base_flat;

	always_comb begin
		for (int c = 0; c < NCH; c++) begin
			base_flat[c*SW +: SW] = base_s3[c];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s4.cov  <= win_s3 && (nc_s3 != '0);
			side_s4.opch <= opch_s3;
			side_s4.base <= base_flat;
			for (int c = 0; c < CHANNELS; c++) begin
				if (2'(c) == opch_s3) begin
					num_s4[c] <= NW'({nc_s3, 1'b0}) + NW'(FULL);
					den_s4[c] <= WW'({FULL, 1'b0});
				end else begin
					num_s4[c] <= pa_s3[c] + pb_s3[c] + NW'(nc_s3 >> 1);
					den_s4[c] <= nc_s3;
				end
			end
		end
	end

	// Divider lanes
	logic [QB-1:0] quo [CHANNELS];

	for (genvar c = 0; c < CHANNELS; c++) begin : g_lane
		aoc_div_pipe #(
			.DW(WW),
			.QB(QB)
		) u_div (
			.clk(clk),
			.en (en),
			.num(num_s4[c]),
			.den(den_s4[c]),
			.quo(quo[c])
		);
	end

	// Valid bits and sideband matched to the divider depth
	logic           vd_s [QB];
	aoc_pkg::side_t sd_s [QB];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < QB; k++) begin
				vd_s[k] <= 1'b0;
			end
		end else if (en) begin
			vd_s[0] <= v_s4;
			for (int k = 1; k < QB; k++) begin
				vd_s[k] <= vd_s[k-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sd_s[0] <= side_s4;
			for (int k = 1; k < QB; k++) begin
				sd_s[k] <= sd_s[k-1];
			end
		end
	end

	// Output register: saturate, pass the base through when not covered, zero unused channels
	logic [aoc_pkg::OUT_DATA_W-1:0] out_d;
	aoc_pkg::side_t                 sd_last;

	always_comb begin
		sd_last = sd_s[QB-1];
		for (int c = 0; c < NCH; c++) begin
			if (c >= CHANNELS) begin
				out_d[c*SW +: SW] = '0;
			end else if (!sd_last.cov) begin
				out_d[c*SW +: SW] = sd_last.base[c*SW +: SW];
			end else if (quo[c] > QB'(LIM)) begin
				out_d[c*SW +: SW] = LIM;
			end else begin
				out_d[c*SW +: SW] = quo[c][SW-1:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (en) begin
			m_tvalid <= vd_s[QB-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			m_tdata <= out_d;
			m_tuser <= sd_last.cov;
		end
	end

`ifndef SYNTHESIS
	// A covered pixel never reaches the divider with a zero divisor
	a_cov_den: assert property (@(posedge clk) disable iff (!arst_n)
		v_s4 && side_s4.cov |-> den_s4[0] != '0)
		else $error("covered pixel with zero divisor");

	// The channel-0 colour quotient is a weighted mean of samples and fits the sample range
	a_color_range: assert property (@(posedge clk) disable iff (!arst_n)
		vd_s[QB-1] && sd_s[QB-1].cov && sd_s[QB-1].opch != 2'd0
		|-> quo[0][QB-1] == 1'b0)
		else $error("colour quotient out of range");

	// A stall freezes the pipeline valid bits
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> $stable(v_s1) && $stable(v_s4) && $stable(vd_s[QB-1]))
		else $error("pipeline moved during stall");
`endif
endmodule
`default_nettype wire

@@ tb/aoc_checker.sv @@
// Checker for the alpha-over compositor: watches both streams, predicts each pixel and compares.
module aoc_checker (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic [aoc_pkg::IN_DATA_W-1:0]  s_tdata,
	input  wire logic                           s_tvalid,
	input  wire logic                           s_tready,
	input  wire logic [aoc_pkg::OUT_DATA_W-1:0] m_tdata,
	input  wire logic                           m_tuser,
	input  wire logic                           m_tvalid,
	input  wire logic                           m_tready,
	input  wire logic                           cfg_we,
	input  wire logic [aoc_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [aoc_pkg::CFG_DATA_W-1:0] cfg_data,
	output int                                  fail_count,
	output int                                  pending
);
	import aoc_pkg::*;

	localparam longint unsigned FS = 65535;

	typedef struct packed {
		logic [15:0] ch3, ch2, ch1, ch0;
		logic        covered;
	} pixel_t;

	pixel_t      expected_pixels[$];
	logic [1:0]  opa_ch;
	logic signed [12:0] off_x, off_y;
	logic [12:0] win_w, win_h;

	assign pending = expected_pixels.size();

	// Porter-Duff over of one pixel
	function automatic pixel_t blend_pixel(logic [IN_DATA_W-1:0] d);
		logic [15:0] bs[4], os[4], res[4];
		int dx, dy;
		bit cov;
		longint unsigned a, b, wa, wb, nc;
		logic [127:0] num;
		pixel_t p;
		dx = int'(d[11:0]) - int'(off_x);
		dy = int'(d[23:12]) - int'(off_y);
		for (int c = 0; c < 4; c++) begin
			bs[c] = d[24 + 16*c +: 16];
			os[c] = d[88 + 16*c +: 16];
			res[c] = bs[c];
		end
		cov = dx >= 0 && dy >= 0 && dx < int'(win_w) && dy < int'(win_h);
		if (cov) begin
			a = bs[opa_ch];
			b = os[opa_ch];
			wb = b * FS;
			wa = (FS - b) * a;
			nc = wb + wa;
			if (nc == 0) cov = 0;
			else begin
				for (int c = 0; c < 4; c++) begin
					if (c == opa_ch) num = (2 * nc + FS) / (2 * FS);
					else begin
						num = 128'(wb) * os[c] + 128'(wa) * bs[c] + nc / 2;
						num = num / nc;
					end
					res[c] = num > FS ? 16'hFFFF : num[15:0];
				end
			end
		end
		p.ch0 = res[0]; p.ch1 = res[1]; p.ch2 = res[2]; p.ch3 = res[3];
		p.covered = cov;
		return p;
	endfunction

	task automatic report_mismatch(string what, int got, int want);
		$display("mismatch %s: got %0d expected %0d", what, got, want);
		fail_count++;
	endtask

	initial fail_count = 0;

	always @(posedge clk or negedge arst_n) begin
		pixel_t want;
		if (!arst_n) begin
			opa_ch <= 2'd3;
			off_x <= '0;
			off_y <= '0;
			win_w <= 13'd4096;
			win_h <= 13'd4096;
		end else begin
			// register writes
			if (cfg_we) begin
				case (cfg_reg_t'(cfg_index))
					REG_OPACITY_CHANNEL: opa_ch <= cfg_data[1:0];
					REG_OFFSET_X:        off_x <= cfg_data;
					REG_OFFSET_Y:        off_y <= cfg_data;
					REG_OVERLAY_WIDTH:   win_w <= cfg_data;
					REG_OVERLAY_HEIGHT:  win_h <= cfg_data;
					default: ;
				endcase
			end
			// input transfer
			if (s_tvalid && s_tready) expected_pixels.push_back(blend_pixel(s_tdata));
			// output transfer
			if (m_tvalid && m_tready) begin
				if (expected_pixels.size() == 0) begin
					report_mismatch("result transfers pending", 1, 0);
				end else begin
					want = expected_pixels.pop_front();
					if (m_tdata[15:0] !== want.ch0)
						report_mismatch("out_ch0", m_tdata[15:0], want.ch0);
					if (m_tdata[31:16] !== want.ch1)
						report_mismatch("out_ch1", m_tdata[31:16], want.ch1);
					if (m_tdata[47:32] !== want.ch2)
						report_mismatch("out_ch2", m_tdata[47:32], want.ch2);
					if (m_tdata[63:48] !== want.ch3)
						report_mismatch("out_ch3", m_tdata[63:48], want.ch3);
					if (m_tuser !== want.covered)
						report_mismatch("covered", m_tuser, want.covered);
				end
			end
		end
	end
endmodule

@@ tb/tb_alpha_over_compositor_core.sv @@
// Testbench top for the alpha-over compositor: stimulus, configuration phases and verdict.
module tb_alpha_over_compositor_core;
	import aoc_pkg::*;

	logic                  clk = 0;
	logic                  arst_n = 0;
	logic [IN_DATA_W-1:0]  s_tdata = '0;
	logic                  s_tvalid = 0;
	logic                  s_tready;
	logic [OUT_DATA_W-1:0] m_tdata;
	logic                  m_tuser, m_tvalid;
	logic                  m_tready = 0;
	logic                  cfg_we = 0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	int                    fail_count, pending;
	bit                    quiet_sink = 0;

	always #4 clk = ~clk;

	alpha_over_compositor_core u_dut (.*);

	aoc_checker u_chk (.*);

	// receiver: random stalls except in quiet stretches
	always @(posedge clk)
		m_tready <= quiet_sink || ($urandom_range(99) >= 25);

	task automatic write_reg(cfg_reg_t idx, logic [12:0] val);
		cfg_we <= 1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 0;
	endtask

	// wait until drained, then past pipeline depth
	task automatic drain();
		while (pending != 0) @(posedge clk);
		repeat (30) @(posedge clk);
	endtask

	// one pixel transfer, with optional idle gaps
	task automatic send_pixel(logic [11:0] px, logic [11:0] py, logic [15:0] bs[4],
			logic [15:0] os[4], bit gaps);
		logic [IN_DATA_W-1:0] d;
		d = {os[3], os[2], os[1], os[0], bs[3], bs[2], bs[1], bs[0], py, px};
		while (gaps && $urandom_range(99) < 25) begin
			s_tvalid <= 0;
			@(posedge clk);
		end
		s_tdata <= d;
		s_tvalid <= 1;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
	endtask

	task automatic rand_pixel(bit gaps, int opc, int mode);
		logic [15:0] bs[4], os[4];
		for (int c = 0; c < 4; c++) begin
			bs[c] = 16'($urandom);
			os[c] = 16'($urandom);
		end
		// opacity extremes now and then
		case (mode)
			1: bs[opc] = 0;
			2: os[opc] = 0;
			3: begin bs[opc] = 0; os[opc] = 0; end
			4: os[opc] = 16'hFFFF;
			5: bs[opc] = 16'hFFFF;
			default: ;
		endcase
		send_pixel(12'($urandom), 12'($urandom), bs, os, gaps);
	endtask

	initial begin
		logic [15:0] bs[4], os[4];
		int opc;
		repeat (4) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed: extremes at reset window
		quiet_sink = 1;
		for (int k = 0; k < 8; k++) begin
			for (int c = 0; c < 4; c++) begin
				bs[c] = k[0] ? 16'hFFFF : 16'h0000;
				os[c] = k[1] ? 16'hFFFF : 16'h0000;
			end
			if (k[2]) begin bs[0] = 16'h1234; os[1] = 16'h8001; end
			send_pixel(k[0] ? 12'hFFF : 12'h000, k[1] ? 12'hFFF : 12'h000, bs, os, 0);
		end
		s_tvalid <= 0;
		drain();

		// directed: small window, edges inside and outside
		write_reg(REG_OFFSET_X, 13'd10);
		write_reg(REG_OFFSET_Y, 13'd20);
		write_reg(REG_OVERLAY_WIDTH, 13'd5);
		write_reg(REG_OVERLAY_HEIGHT, 13'd1);
		write_reg(REG_OPACITY_CHANNEL, 13'd0);
		for (int k = 0; k < 8; k++) begin
			for (int c = 0; c < 4; c++) begin
				bs[c] = 16'($urandom);
				os[c] = 16'($urandom);
			end
			send_pixel(12'(9 + (k % 4) * 2), 12'(19 + k / 4 + (k % 2)), bs, os, 0);
		end
		s_tvalid <= 0;
		drain();
		quiet_sink = 0;

		// random phases across several settings
		for (int ph = 0; ph < 8; ph++) begin
			opc = (ph == 0) ? 3 : $urandom_range(3);
			write_reg(REG_OPACITY_CHANNEL, 13'(opc));
			case (ph)
				0: begin
					write_reg(REG_OFFSET_X, 13'h1000);
					write_reg(REG_OFFSET_Y, 13'h1000);
					write_reg(REG_OVERLAY_WIDTH, 13'd4096);
					write_reg(REG_OVERLAY_HEIGHT, 13'd4096);
				end
				1: begin
					write_reg(REG_OFFSET_X, 13'h0FFF);
					write_reg(REG_OFFSET_Y, 13'h0FFF);
					write_reg(REG_OVERLAY_WIDTH, 13'd1);
					write_reg(REG_OVERLAY_HEIGHT, 13'd1);
				end
				2: begin
					write_reg(REG_OVERLAY_WIDTH, 13'd0);
					write_reg(REG_OVERLAY_HEIGHT, 13'd4096);
				end
				default: begin
					write_reg(REG_OFFSET_X, 13'($urandom_range(4096) - 1024));
					write_reg(REG_OFFSET_Y, 13'($urandom_range(4096) - 1024));
					write_reg(REG_OVERLAY_WIDTH, 13'($urandom_range(4096, 1)));
					write_reg(REG_OVERLAY_HEIGHT, 13'($urandom_range(4096, 1)));
				end
			endcase
			quiet_sink = (ph == 4);
			for (int n = 0; n < 225; n++)
				rand_pixel(ph != 4, opc, $urandom_range(9));
			s_tvalid <= 0;
			drain();
		end

		if (fail_count == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

	initial begin
		#2000000;
		$display("Verification failed");
		$finish;
	end
endmodule

@@ sim.f @@
design/aoc_pkg.sv
design/aoc_div_pipe.sv
design/alpha_over_compositor_core.sv
tb/aoc_checker.sv
tb/tb_alpha_over_compositor_core.sv
